/* rtl/core/mgf_pkg.sv */
// Shared types, constants and helpers of the missing time gap filler.
`default_nettype none
package mgf_pkg;

  localparam int MAX_SCANS   = 64;
  localparam int IDX_W       = $clog2(MAX_SCANS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int TIME_W      = 48;
  localparam int FLAG_W      = 16;
  localparam int FILL_BIT    = 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int PROD_W      = 56;
  localparam int DIGIT_W     = 8;
  localparam int DIV_STEPS   = PROD_W / DIGIT_W;
  localparam int SUM_W       = PROD_W + 2;

  localparam logic signed [TIME_W-1:0] MISS_A = -48'sd1047527424;
  localparam logic signed [TIME_W-1:0] MISS_B = -48'sd34358689792;

  typedef struct packed {
    logic signed [TIME_W-1:0] scan_time;
    logic [FLAG_W-1:0]        quality_flags;
    logic                     last_scan;
  } in_t;

  typedef struct packed {
    logic signed [TIME_W-1:0] filled_time;
    logic [FLAG_W-1:0]        flags_out;
    logic                     fill_failed;
    logic                     last_result;
  } out_t;

  typedef struct packed {
    logic                     miss;
    logic [FLAG_W-1:0]        flags;
    logic signed [TIME_W-1:0] t;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    logic [IDX_W-1:0] last_v;
    logic [IDX_W-1:0] prevlast;
    logic             failed;
  } job_t;

  function automatic logic is_missing(input logic signed [TIME_W-1:0] t);
    return (t == MISS_A) || (t == MISS_B);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/mgf_ram.sv */
// Generic single write, single read RAM with registered read data.
`default_nettype none
module mgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/mgf_front.sv */
// Front end: load scans, mark missing times, track valid anchors, close sets.
`default_nettype none
module mgf_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire mgf_pkg::in_t           item,
  input  wire logic                   set_done,
  output logic                        busy,
  output logic                        wr_en,
  output logic [mgf_pkg::IDX_W-1:0]   wr_addr,
  output mgf_pkg::entry_t             wr_data,
  output logic                        push,
  output mgf_pkg::job_t               job
);
  import mgf_pkg::*;

  logic [CNT_W-1:0] count;
  logic [1:0]       nv;
  logic [IDX_W-1:0] first, second, last_v, prevlast;
  logic             anymiss;
  logic             held;

  logic [1:0]       nv_next;
  logic [IDX_W-1:0] first_next, second_next, last_next, prevlast_next;
  logic             anymiss_next;
  logic             accept, miss, closing;
  logic [IDX_W-1:0] idx;

  assign accept  = start && !held;
  assign miss    = is_missing(item.scan_time);
  assign idx     = count[IDX_W-1:0];
  assign closing = accept && (item.last_scan || count == CNT_W'(MAX_SCANS - 1));

  always_comb begin
    first_next    = (!miss && nv == 2'd0) ? idx : first;
    second_next   = (!miss && nv == 2'd1) ? idx : second;
    prevlast_next = !miss ? last_v : prevlast;
    last_next     = !miss ? idx : last_v;
    nv_next       = (!miss && nv != 2'd2) ? nv + 2'd1 : nv;
    anymiss_next  = anymiss || miss;
  end

  assign busy    = held;
  assign wr_en   = accept;
  assign wr_addr = idx;
  assign wr_data = '{miss: miss, flags: item.quality_flags, t: item.scan_time};
  assign push    = closing;

  always_comb begin
    job.n        = count + CNT_W'(1);
    job.first    = first_next;
    job.second   = second_next;
    job.last_v   = last_next;
    job.prevlast = prevlast_next;
    job.failed   = anymiss_next && (nv_next < 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      nv      <= '0;
      anymiss <= 1'b0;
      held    <= 1'b0;
    end else begin
      if (set_done) begin
        held <= 1'b0;
      end
      if (accept) begin
        if (closing) begin
          count   <= '0;
          nv      <= '0;
          anymiss <= 1'b0;
          held    <= 1'b1;
        end else begin
          count   <= count + CNT_W'(1);
          nv      <= nv_next;
          anymiss <= anymiss_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first    <= first_next;
      second   <= second_next;
      last_v   <= last_next;
      prevlast <= prevlast_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mgf_queue.sv */
// Short queue of closed set descriptors between front and back.
`default_nettype none
module mgf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire mgf_pkg::job_t din,
  input  wire logic          pop,
  output mgf_pkg::job_t      dout,
  output logic               not_empty
);
  import mgf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0]   fill;

  assign not_empty = (fill != '0);
  assign dout      = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop && not_empty) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      fill <= fill + (PTR_W+1)'(push) - (PTR_W+1)'(pop && not_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mgf_back.sv */
// Back end: walk a closed set, search neighbours, interpolate and emit words.
`default_nettype none
module mgf_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire mgf_pkg::job_t          job,
  input  wire logic                   job_ready,
  output logic                        pop,
  output logic [mgf_pkg::IDX_W-1:0]   raddr,
  input  wire mgf_pkg::entry_t        rdata,
  output logic                        result_valid,
  output mgf_pkg::out_t               result,
  output logic                        set_done
);
  import mgf_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam logic signed [SUM_W-1:0] TMAX = SUM_W'(48'sh7FFF_FFFF_FFFF);
  localparam logic signed [SUM_W-1:0] TMIN = -TMAX - SUM_W'(1);
  localparam logic [FLAG_W-1:0] FILL_MASK = FLAG_W'(1) << FILL_BIT;

  typedef enum logic [3:0] {
    S_IDLE, S_RDK, S_CHK, S_SRD, S_SCHK, S_RDF, S_RDT, S_MUL, S_ABS, S_DIV, S_FIN
  } state_t;

  state_t                    state;
  logic [IDX_W-1:0]          k, n_last, first, second, last_v, prevlast;
  logic                      failed;
  logic [IDX_W-1:0]          av, bidx, srch, from, to, idx_gap, span;
  logic                      bvalid, sub, tail, neg;
  logic [FLAG_W-1:0]         cur_flags;
  logic signed [TIME_W-1:0]  tfrom, anchor;
  logic signed [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]         mag;
  logic [IDX_W-1:0]          rem;
  logic [STEP_W-1:0]         stepc;

  logic                      fill, emit;
  out_t                      emit_res;
  logic signed [TIME_W:0]    diff;
  logic signed [PROD_W-1:0]  prod_calc;
  logic [PROD_W-1:0]         mag_next;
  logic [IDX_W-1:0]          rem_next;
  logic signed [SUM_W-1:0]   q, sum;
  logic signed [TIME_W-1:0]  sat;

  assign fill = rdata.miss && !failed;
  assign pop  = (state == S_IDLE) && job_ready;

  always_comb begin
    unique case (state)
      S_SRD:   raddr = srch;
      S_RDF:   raddr = from;
      S_RDT:   raddr = to;
      default: raddr = k;
    endcase
  end

  assign diff      = {rdata.t[TIME_W-1], rdata.t} - {tfrom[TIME_W-1], tfrom};
  assign prod_calc = diff * $signed({1'b0, idx_gap});

  always_comb begin
    logic [IDX_W:0]   r7;
    logic [IDX_W-1:0] r;
    logic [PROD_W-1:0] m;
    r = rem;
    m = mag;
    for (int i = 0; i < DIGIT_W; i++) begin
      r7 = {r, m[PROD_W-1]};
      m  = m << 1;
      if (r7 >= {1'b0, span}) begin
        r7   = r7 - {1'b0, span};
        m[0] = 1'b1;
      end
      r = r7[IDX_W-1:0];
    end
    rem_next = r;
    mag_next = m;
  end

  always_comb begin
    q   = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    sum = sub ? SUM_W'(anchor) - q : SUM_W'(anchor) + q;
    if (sum > TMAX) begin
      sat = TMAX[TIME_W-1:0];
    end else if (sum < TMIN) begin
      sat = TMIN[TIME_W-1:0];
    end else begin
      sat = sum[TIME_W-1:0];
    end
  end

  always_comb begin
    emit     = 1'b0;
    emit_res = '{filled_time: rdata.t,
                 flags_out:   rdata.flags | (rdata.miss ? FILL_MASK : '0),
                 fill_failed: failed,
                 last_result: (k == n_last)};
    if (state == S_CHK && !fill) begin
      emit = 1'b1;
    end else if (state == S_FIN) begin
      emit     = 1'b1;
      emit_res = '{filled_time: sat, flags_out: cur_flags | FILL_MASK,
                   fill_failed: 1'b0, last_result: (k == n_last)};
    end
  end

  assign set_done = emit && (k == n_last);

  always_ff @(posedge clk) begin
    result <= emit_res;
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
      if (emit) begin
        state <= (k == n_last) ? S_IDLE : S_RDK;
      end else begin
        unique case (state)
          S_IDLE: if (job_ready) begin
            state <= S_RDK;
          end
          S_RDK:  state <= S_CHK;
          S_CHK: begin
            if (rdata.miss && k >= first && k <= last_v && !(bvalid && bidx > k)) begin
              state <= S_SRD;
            end else begin
              state <= S_RDF;
            end
          end
          S_SRD:  state <= S_SCHK;
          S_SCHK: state <= rdata.miss ? S_SRD : S_RDF;
          S_RDF:  state <= S_RDT;
          S_RDT:  state <= S_MUL;
          S_MUL:  state <= S_ABS;
          S_ABS:  state <= S_DIV;
          S_DIV: if (stepc == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_FIN;
          end
          S_FIN:  state <= S_FIN;
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      k <= k + IDX_W'(1);
    end
    unique case (state)
      S_IDLE: begin
        k        <= '0;
        n_last   <= IDX_W'(job.n - CNT_W'(1));
        first    <= job.first;
        second   <= job.second;
        last_v   <= job.last_v;
        prevlast <= job.prevlast;
        failed   <= job.failed;
        bvalid   <= 1'b0;
        av       <= '0;
      end
      S_CHK: begin
        cur_flags <= rdata.flags;
        if (!rdata.miss) begin
          av <= k;
        end
        if (k < first) begin
          from    <= first;
          to      <= second;
          idx_gap <= first - k;
          sub     <= 1'b1;
          tail    <= 1'b0;
        end else if (k > last_v) begin
          from    <= prevlast;
          to      <= last_v;
          idx_gap <= k - last_v;
          sub     <= 1'b0;
          tail    <= 1'b1;
        end else begin
          from    <= av;
          to      <= bidx;
          idx_gap <= k - av;
          sub     <= 1'b0;
          tail    <= 1'b0;
          srch    <= k + IDX_W'(1);
        end
      end
      S_SCHK: begin
        if (rdata.miss) begin
          srch <= srch + IDX_W'(1);
        end else begin
          to     <= srch;
          bidx   <= srch;
          bvalid <= 1'b1;
        end
      end
      S_RDF: span  <= to - from;
      S_RDT: tfrom <= rdata.t;
      S_MUL: begin
        prod   <= prod_calc;
        anchor <= tail ? rdata.t : tfrom;
      end
      S_ABS: begin
        neg   <= prod[PROD_W-1];
        mag   <= prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        rem   <= '0;
        stepc <= '0;
      end
      S_DIV: begin
        mag   <= mag_next;
        rem   <= rem_next;
        stepc <= stepc + STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/missing_time_gap_filler.sv */
// Top level of the missing scan time gap filler.
//
//  channel   handshake              payload
//  input     start / busy           item   (mgf_pkg::in_t)
//  result    result_valid strobe    result (mgf_pkg::out_t)
//
// Loading takes one word per cycle while busy is low; a set closes on last_scan
// or at 64 scans. Emission: each set first takes its descriptor; a scan with a
// valid time or an unfillable gap is a RAM read, then emit; a filled scan adds
// a forward neighbour search where needed, two time reads, a multiply and a
// radix-256 divider before it is emitted.
// busy stays high from set close until the last result word leaves.
// Synchronous active-high reset; no clearing pass. Results cannot be stalled.
`default_nettype none
module missing_time_gap_filler (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire mgf_pkg::in_t item,
  output logic              busy,
  output logic              result_valid,
  output mgf_pkg::out_t     result
);
  import mgf_pkg::*;

  logic             wr_en, push, pop, job_ready, set_done;
  logic [IDX_W-1:0] wr_addr, raddr;
  entry_t           wr_data, rdata;
  job_t             job_in, job_out;
  logic [ENTRY_W-1:0] rdata_raw;

  mgf_front u_front (
    .clk(clk), .rst(rst), .start(start), .item(item), .set_done(set_done),
    .busy(busy), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .push(push), .job(job_in)
  );

  mgf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SCANS)) u_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .raddr(raddr), .rdata(rdata_raw)
  );

  assign rdata = entry_t'(rdata_raw);

  mgf_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(job_in), .pop(pop),
    .dout(job_out), .not_empty(job_ready)
  );

  mgf_back u_back (
    .clk(clk), .rst(rst), .job(job_out), .job_ready(job_ready), .pop(pop),
    .raddr(raddr), .rdata(rdata), .result_valid(result_valid),
    .result(result), .set_done(set_done)
  );

`ifndef ASSERT_OFF
  a_result_in_set: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result word outside an open set");

  a_close_holds: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last_scan) |=> busy)
    else $error("set close did not raise busy");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_result) |-> !busy)
    else $error("busy still high after final result word");
`endif

endmodule
`default_nettype wire
